@@ rtl/alarm_slot_scheduler_unit_defines.svh @@
// Assertion macros used by the alarm slot scheduler control block (asched_ctrl).
`ifndef ALARM_SLOT_SCHEDULER_UNIT_DEFINES_SVH
`define ALARM_SLOT_SCHEDULER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define ASU_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASU_ASSERT(lbl, expr, msg)
`define ASU_ASSERT_IMP(lbl, ante, cons, msg)
`define ASU_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ rtl/asched_pkg.sv @@
package asched_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY,
    ST_FLUSH
  } sched_state_t;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_PROG = 1'b1
  } func_t;

  // Result transfer request from the sequencer to the output register
  typedef struct packed {
    logic valid;
    logic last;
  } push_ctl_t;

endpackage

@@ rtl/alarm_slot_scheduler_unit.sv @@
// A program item scans every slot, then applies its update to the slot table (slot scan, apply).
// A tick scans one slot per cycle unless a stalled result output holds it, then flushes; its
// last fired type is pushed to the outputs in the flush, earlier ones when the next fire is
// found and the output register can take them. A new item is taken only in idle (scan, apply or flush, then idle);
// a stalled result output holds the scan and the flush.
// Reset: clears slot busy bits, the sequencer and the output register's valid bit, not the slot table.
module alarm_slot_scheduler_unit
  import asched_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  parameter int TYPE_BITS = 8,
  parameter int DELAY_BITS = 23
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [TYPE_BITS-1:0]  in_alarm_type,
  input  logic                  in_alarm_periodic,
  input  logic [DELAY_BITS-1:0] in_alarm_delay,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [TYPE_BITS-1:0]  out_fired_type,
  output logic                  out_last_fired
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int WORD_W = TYPE_BITS + 1 + 2 * DELAY_BITS;

  push_ctl_t push;
  logic [TYPE_BITS-1:0] push_type;
  logic push_ready;
  logic [IDX_W-1:0] ram_rd_addr;
  logic [WORD_W-1:0] ram_rd_data;
  logic ram_we;
  logic [IDX_W-1:0] ram_wr_addr;
  logic [WORD_W-1:0] ram_wr_data;

  logic out_valid_r;
  logic [TYPE_BITS-1:0] out_fired_type_r;
  logic out_last_fired_r;

  asched_ctrl #(
    .NUM_SLOTS (NUM_SLOTS),
    .TYPE_BITS (TYPE_BITS),
    .DELAY_BITS(DELAY_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_alarm_type    (in_alarm_type),
    .in_alarm_periodic(in_alarm_periodic),
    .in_alarm_delay   (in_alarm_delay),
    .push             (push),
    .push_type        (push_type),
    .push_ready       (push_ready),
    .ram_rd_addr      (ram_rd_addr),
    .ram_rd_data      (ram_rd_data),
    .ram_we           (ram_we),
    .ram_wr_addr      (ram_wr_addr),
    .ram_wr_data      (ram_wr_data)
  );

  asched_ram #(
    .WIDTH(WORD_W),
    .DEPTH(NUM_SLOTS)
  ) u_slot_ram (
    .clk    (clk),
    .we     (ram_we),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_addr(ram_rd_addr),
    .rd_data(ram_rd_data)
  );

  // Output register: load when empty or when its result transfers
  assign push_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push_ready) begin
      out_valid_r <= push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && push_ready) begin
      out_fired_type_r <= push_type;
      out_last_fired_r <= push.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_fired_type = out_fired_type_r;
  assign out_last_fired = out_last_fired_r;

endmodule

@@ rtl/asched_ram.sv @@
module asched_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/asched_ctrl.sv @@
`include "alarm_slot_scheduler_unit_defines.svh"

module asched_ctrl
  import asched_pkg::*;
#(
  parameter int NUM_SLOTS = 8,
  parameter int TYPE_BITS = 8,
  parameter int DELAY_BITS = 23,
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1,
  localparam int WORD_W = TYPE_BITS + 1 + 2 * DELAY_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_func,
  input  logic [TYPE_BITS-1:0]  in_alarm_type,
  input  logic                  in_alarm_periodic,
  input  logic [DELAY_BITS-1:0] in_alarm_delay,
  output push_ctl_t             push,
  output logic [TYPE_BITS-1:0]  push_type,
  input  logic                  push_ready,
  output logic [IDX_W-1:0]      ram_rd_addr,
  input  logic [WORD_W-1:0]     ram_rd_data,
  output logic                  ram_we,
  output logic [IDX_W-1:0]      ram_wr_addr,
  output logic [WORD_W-1:0]     ram_wr_data
);

  // Entry layout: {type, periodic, period, remaining}
  localparam int REM_LO = 0;
  localparam int PER_LO = DELAY_BITS;
  localparam int PDC_BIT = 2 * DELAY_BITS;
  localparam int TYP_LO = 2 * DELAY_BITS + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  sched_state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [NUM_SLOTS-1:0] busy_r, busy_nxt;
  func_t func_r, func_nxt;
  logic [TYPE_BITS-1:0] type_r, type_nxt;
  logic periodic_r, periodic_nxt;
  logic [DELAY_BITS-1:0] delay_r, delay_nxt;
  logic match_found_r, match_found_nxt;
  logic [IDX_W-1:0] match_idx_r, match_idx_nxt;
  logic match_periodic_r, match_periodic_nxt;
  logic [DELAY_BITS-1:0] match_period_r, match_period_nxt;
  logic free_found_r, free_found_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic pend_valid_r, pend_valid_nxt;
  logic [TYPE_BITS-1:0] pend_type_r, pend_type_nxt;

  logic [TYPE_BITS-1:0] rd_type;
  logic rd_periodic;
  logic [DELAY_BITS-1:0] rd_period;
  logic [DELAY_BITS-1:0] rd_rem;
  logic adv;

  assign rd_rem = ram_rd_data[REM_LO +: DELAY_BITS];
  assign rd_period = ram_rd_data[PER_LO +: DELAY_BITS];
  assign rd_periodic = ram_rd_data[PDC_BIT];
  assign rd_type = ram_rd_data[TYP_LO +: TYPE_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r <= '0;
      pend_valid_r <= 1'b0;
      match_found_r <= 1'b0;
      free_found_r <= 1'b0;
      idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r <= busy_nxt;
      pend_valid_r <= pend_valid_nxt;
      match_found_r <= match_found_nxt;
      free_found_r <= free_found_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    type_r <= type_nxt;
    periodic_r <= periodic_nxt;
    delay_r <= delay_nxt;
    match_idx_r <= match_idx_nxt;
    match_periodic_r <= match_periodic_nxt;
    match_period_r <= match_period_nxt;
    free_idx_r <= free_idx_nxt;
    pend_type_r <= pend_type_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    busy_nxt = busy_r;
    func_nxt = func_r;
    type_nxt = type_r;
    periodic_nxt = periodic_r;
    delay_nxt = delay_r;
    match_found_nxt = match_found_r;
    match_idx_nxt = match_idx_r;
    match_periodic_nxt = match_periodic_r;
    match_period_nxt = match_period_r;
    free_found_nxt = free_found_r;
    free_idx_nxt = free_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_type_nxt = pend_type_r;
    adv = 1'b0;
    in_stall = (state_r != ST_IDLE);
    push = '0;
    push_type = pend_type_r;
    ram_rd_addr = idx_r;
    ram_we = 1'b0;
    ram_wr_addr = idx_r;
    ram_wr_data = ram_rd_data;

    unique case (state_r)
      ST_IDLE: begin
        ram_rd_addr = '0;
        if (in_valid) begin
          state_nxt = ST_EVAL;
          idx_nxt = '0;
          func_nxt = func_t'(in_func);
          type_nxt = in_alarm_type;
          periodic_nxt = in_alarm_periodic;
          delay_nxt = in_alarm_delay;
          match_found_nxt = 1'b0;
          free_found_nxt = 1'b0;
          pend_valid_nxt = 1'b0;
        end
      end
      ST_EVAL: begin
        adv = 1'b1;
        if (func_r == FUNC_PROG) begin
          // Later matches override, so the highest slot wins
          if (busy_r[idx_r] && (rd_type == type_r)) begin
            match_found_nxt = 1'b1;
            match_idx_nxt = idx_r;
            match_periodic_nxt = rd_periodic;
            match_period_nxt = rd_period;
          end
          if (!busy_r[idx_r] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt = idx_r;
          end
        end else if (busy_r[idx_r]) begin
          if (rd_rem <= DELAY_BITS'(1)) begin
            // Hold the pending fire until the previous one transfers
            if (pend_valid_r) begin
              push.valid = 1'b1;
              push.last = 1'b0;
              adv = push_ready;
            end
            if (adv) begin
              pend_valid_nxt = 1'b1;
              pend_type_nxt = rd_type;
              if (rd_periodic) begin
                ram_we = 1'b1;
                ram_wr_data[REM_LO +: DELAY_BITS] = rd_period;
              end else begin
                busy_nxt[idx_r] = 1'b0;
              end
            end
          end else begin
            ram_we = 1'b1;
            ram_wr_data[REM_LO +: DELAY_BITS] = rd_rem - DELAY_BITS'(1);
          end
        end
        if (adv) begin
          if (idx_r == LAST_IDX) begin
            state_nxt = (func_r == FUNC_PROG) ? ST_APPLY : ST_FLUSH;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        ram_rd_addr = idx_nxt;
      end
      ST_APPLY: begin
        state_nxt = ST_IDLE;
        if (match_found_r) begin
          if (delay_r == '0) begin
            busy_nxt[match_idx_r] = 1'b0;
          end else begin
            ram_we = 1'b1;
            ram_wr_addr = match_idx_r;
            ram_wr_data = {type_r, match_periodic_r, match_period_r, delay_r};
          end
        end else if (free_found_r) begin
          ram_we = 1'b1;
          ram_wr_addr = free_idx_r;
          ram_wr_data = {type_r, periodic_r, delay_r, delay_r};
          busy_nxt[free_idx_r] = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (pend_valid_r) begin
          push.valid = 1'b1;
          push.last = 1'b1;
          if (push_ready) begin
            pend_valid_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  `ASU_ASSERT_IMP(a_we_state, ram_we, (state_r == ST_EVAL) || (state_r == ST_APPLY), "write outside eval or apply")
  `ASU_ASSERT_IMP(a_push_pend, push.valid, pend_valid_r, "push without pending fire")
  `ASU_ASSERT_IMP(a_push_tick, push.valid, func_r == FUNC_TICK, "push during program item")
  `ASU_ASSERT_NXT(a_apply_done, state_r == ST_APPLY, state_r == ST_IDLE, "apply did not finish")

endmodule
